@@ design/psma_pkg.sv @@
package psma_pkg;

  // Input item codes
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Packet framing
  localparam logic [2:0] PKT_BYTES_WHEEL = 3'd4;
  localparam logic [2:0] PKT_BYTES_RESET = 3'd3;
  localparam int unsigned SYNC_BIT       = 3;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic              event_valid;
    logic [2:0]        buttons;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic signed [7:0] wheel_delta;
  } out_item_t;

  // One queued mouse event
  typedef struct packed {
    logic [2:0]        buttons;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic signed [7:0] wheel_delta;
  } event_t;

  // Completed packet handed from the assembler to the queue
  typedef struct packed {
    logic   valid;
    event_t evt;
  } push_t;

endpackage

@@ design/psma_asm.sv @@
module psma_asm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_go,
  input  logic [7:0]            data_byte,
  input  logic [2:0]            packet_bytes,
  output psma_pkg::push_t       push
);

  logic [1:0] byte_index;
  logic [1:0] byte_index_next;
  logic [7:0] pkt0;
  logic [7:0] pkt1;
  logic [7:0] pkt2;

  logic       wide;
  logic [2:0] size;
  logic [2:0] held;
  logic       drop;
  logic       done;
  logic [7:0] byte2;

  // Decode framing for the incoming byte
  always_comb begin
    wide  = (packet_bytes == psma_pkg::PKT_BYTES_WHEEL);
    size  = wide ? 3'd4 : 3'd3;
    held  = {1'b0, byte_index} + 3'd1;
    drop  = (byte_index == 2'd0) && !data_byte[psma_pkg::SYNC_BIT];
    done  = byte_go && !drop && (held >= size);
    byte2 = (byte_index == 2'd2) ? data_byte : pkt2;

    byte_index_next = byte_index;
    if (byte_go && !drop) begin
      byte_index_next = (held >= size) ? 2'd0 : held[1:0];
    end

    push.valid           = done;
    push.evt.buttons     = pkt0[2:0];
    push.evt.move_x      = pkt1;
    push.evt.move_y      = byte2;
    push.evt.wheel_delta = (wide && held == 3'd4) ? data_byte : 8'd0;
  end

  // Advance packet position
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= 2'd0;
    end else begin
      byte_index <= byte_index_next;
    end
  end

  // Hold packet bytes
  always_ff @(posedge clk) begin
    if (byte_go && !drop) begin
      case (byte_index)
        2'd0:    pkt0 <= data_byte;
        2'd1:    pkt1 <= data_byte;
        2'd2:    pkt2 <= data_byte;
        default: ;
      endcase
    end
  end

endmodule

@@ design/psma_queue.sv @@
module psma_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  psma_pkg::push_t       push,
  input  logic                  pop_go,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic                  slot_free,
  output psma_pkg::out_item_t   out_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  psma_pkg::event_t mem [QUEUE_DEPTH];
  psma_pkg::event_t rd_data;

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr_inc;
  logic [PTR_W-1:0] rd_ptr_inc;
  logic             empty;
  logic             full;
  logic             hit;
  logic             do_write;
  logic             do_read;

  // Ring pointer arithmetic
  always_comb begin
    wr_ptr_inc = (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
    rd_ptr_inc = (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
    empty      = (rd_ptr == wr_ptr);
    full       = (wr_ptr_inc == rd_ptr);
    do_write   = push.valid && !full;
    do_read    = pop_go && !empty;
    slot_free  = !out_valid || !out_stall;
  end

  // Advance pointers and result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_valid <= 1'b0;
      hit       <= 1'b0;
    end else begin
      if (do_write) begin
        wr_ptr <= wr_ptr_inc;
      end
      if (do_read) begin
        rd_ptr <= rd_ptr_inc;
      end
      if (pop_go) begin
        out_valid <= 1'b1;
        hit       <= !empty;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Event memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_ptr] <= push.evt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_go) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // Zero the fields on an empty pop
  always_comb begin
    out_item.event_valid = hit;
    out_item.buttons     = hit ? rd_data.buttons     : 3'd0;
    out_item.move_x      = hit ? rd_data.move_x      : 8'sd0;
    out_item.move_y      = hit ? rd_data.move_y      : 8'sd0;
    out_item.wheel_delta = hit ? rd_data.wheel_delta : 8'sd0;
  end

endmodule

@@ design/ps2_mouse_packet_assembler.sv @@
// PS/2 mouse packet assembler: takes one item per cycle, either a mouse byte
// or a pop request. Bytes build 3- or 4-byte packets (cfg_data = 4 selects the
// wheel format, any other value means 3); a packet start without bit 3 set is
// dropped. Finished packets enter a ring queue of QUEUE_DEPTH slots, of which
// QUEUE_DEPTH-1 hold events; a packet arriving at a full queue is lost. Each
// pop is accepted into the input register and then loaded into the result
// register, with event_valid low and zero fields when the queue was empty.
// Throughput is one item per cycle while in_stall is low: each item needs
// only a packet position update and at most one event memory access. While a
// pop sits in the input register and the result register is full with
// out_stall high, in_stall holds off the next item. cfg_ready is always high;
// write packet_bytes only while no items are in flight.
module ps2_mouse_packet_assembler #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  psma_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output psma_pkg::out_item_t   out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_data
);

  logic               in_reg_valid;
  psma_pkg::in_item_t in_reg;
  logic [2:0]         packet_bytes;
  logic               slot_free;
  logic               is_pop;
  logic               byte_go;
  logic               pop_go;
  psma_pkg::push_t    push;

  assign cfg_ready = 1'b1;

  // Issue control: a pop waits for the result register
  always_comb begin
    is_pop   = (in_reg.mode == psma_pkg::MODE_POP);
    byte_go  = in_reg_valid && !is_pop;
    pop_go   = in_reg_valid && is_pop && slot_free;
    in_stall = in_reg_valid && is_pop && !slot_free;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_reg <= in_item;
    end
  end

  // Packet size register
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_bytes <= psma_pkg::PKT_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      packet_bytes <= cfg_data;
    end
  end

  psma_asm u_asm (
    .clk          (clk),
    .rst          (rst),
    .byte_go      (byte_go),
    .data_byte    (in_reg.data_byte),
    .packet_bytes (packet_bytes),
    .push         (push)
  );

  psma_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop_go    (pop_go),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .slot_free (slot_free),
    .out_item  (out_item)
  );

endmodule

@@ design/psma_checker.sv @@
module psma_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input psma_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input psma_pkg::out_item_t out_item
);

  // A waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // An empty pop carries zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.event_valid |->
      out_item.buttons == 3'd0 && out_item.move_x == 8'sd0 &&
      out_item.move_y == 8'sd0 && out_item.wheel_delta == 8'sd0)
    else $error("empty pop with nonzero fields");

  // A fresh result follows an accepted pop
  a_result_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |->
      $past(in_valid && !in_stall && in_item.mode == psma_pkg::MODE_POP, 2))
    else $error("result without an accepted pop");

  // Input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result side free");

endmodule

bind ps2_mouse_packet_assembler psma_checker u_psma_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

@@ test/ps2_mouse_event_checker.sv @@
`timescale 1ns / 1ps

module ps2_mouse_event_checker #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  psma_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  psma_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [2:0]          cfg_data,
  output int                  pending,
  output int                  fail_count
);

  // Shadow of the block: packet size, assembly position and the event ring
  logic [2:0]          size_reg;
  logic [1:0]          byte_pos;
  logic [7:0]          held_bytes [3];
  psma_pkg::event_t    queued_events [$];
  psma_pkg::out_item_t pop_results_due [$];
  int                  mismatches = 0;

  // Collect one mouse byte; queue the event when the packet is complete
  task automatic take_mouse_byte(input logic [7:0] b);
    logic             wide;
    int unsigned      needed;
    int unsigned      held;
    psma_pkg::event_t ev;
    wide   = (size_reg == psma_pkg::PKT_BYTES_WHEEL);
    needed = wide ? 4 : 3;
    // drop a packet start without the sync bit
    if (byte_pos == 2'd0 && !b[psma_pkg::SYNC_BIT]) return;
    if (byte_pos < 2'd3) held_bytes[byte_pos] = b;
    held = byte_pos + 1;
    if (held < needed) begin
      byte_pos = held[1:0];
      return;
    end
    byte_pos = 2'd0;
    // lose the event when only the spare slot is left
    if (queued_events.size() >= QUEUE_DEPTH - 1) return;
    ev.buttons     = held_bytes[0][2:0];
    ev.move_x      = held_bytes[1];
    ev.move_y      = held_bytes[2];
    ev.wheel_delta = (wide && held == 4) ? b : 8'h00;
    queued_events.push_back(ev);
  endtask

  task automatic report_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    psma_pkg::out_item_t due;
    psma_pkg::event_t    ev;
    if (rst) begin
      size_reg = psma_pkg::PKT_BYTES_RESET;
      byte_pos = 2'd0;
      queued_events.delete();
      pop_results_due.delete();
    end else begin
      // track register writes
      if (cfg_valid && cfg_ready) size_reg = cfg_data;

      // predict the result of each accepted item
      if (in_valid && !in_stall) begin
        if (in_item.mode == psma_pkg::MODE_POP) begin
          due = '0;
          if (queued_events.size() != 0) begin
            ev               = queued_events.pop_front();
            due.event_valid  = 1'b1;
            due.buttons      = ev.buttons;
            due.move_x       = ev.move_x;
            due.move_y       = ev.move_y;
            due.wheel_delta  = ev.wheel_delta;
          end
          pop_results_due.push_back(due);
        end else begin
          take_mouse_byte(in_item.data_byte);
        end
      end

      // compare each accepted result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (pop_results_due.size() == 0) begin
          $error("Unexpected result item: no pop outstanding");
          mismatches++;
        end else begin
          due = pop_results_due.pop_front();
          report_field("event_valid", int'(due.event_valid), int'(out_item.event_valid));
          report_field("buttons", int'(due.buttons), int'(out_item.buttons));
          report_field("move_x", int'(due.move_x), int'(out_item.move_x));
          report_field("move_y", int'(due.move_y), int'(out_item.move_y));
          report_field("wheel_delta", int'(due.wheel_delta), int'(out_item.wheel_delta));
        end
      end
    end
    pending    <= pop_results_due.size();
    fail_count <= mismatches;
  end

endmodule

@@ test/ps2_mouse_packet_assembler_tb.sv @@
`timescale 1ns / 1ps

module ps2_mouse_packet_assembler_tb;

  localparam int QUEUE_DEPTH   = 64;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  psma_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  psma_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_data  = psma_pkg::PKT_BYTES_RESET;

  int         pending;
  int         fail_count;
  int         items_sent  = 0;
  int         pops_sent   = 0;
  int         floods_done = 0;
  int         cfg_writes  = 0;
  int         idle_cycles = 0;
  logic [2:0] size_now    = psma_pkg::PKT_BYTES_RESET;
  bit         calm        = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ps2_mouse_packet_assembler #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  ps2_mouse_event_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) event_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .fail_count(fail_count)
  );

  // Abort when no channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: insert a random stall before each item
  initial begin
    int k;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      k = calm ? 0 : $urandom_range(0, 4);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic m, input logic [7:0] b);
    psma_pkg::in_item_t it;
    int                 gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.mode      = m;
    it.data_byte = b;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (m == psma_pkg::MODE_POP) pops_sent++;
  endtask

  task automatic send_pop();
    send_item(psma_pkg::MODE_POP, 8'($urandom_range(0, 255)));
  endtask

  // Well-formed packet with random content; optionally cut short
  task automatic send_random_packet(input bit allow_cut);
    logic [7:0] first;
    int         len;
    len   = (size_now == psma_pkg::PKT_BYTES_WHEEL) ? 4 : 3;
    if (allow_cut && $urandom_range(0, 9) == 0) len = $urandom_range(1, len - 1);
    first = 8'($urandom_range(0, 255));
    first[psma_pkg::SYNC_BIT] = 1'b1;
    send_item(psma_pkg::MODE_BYTE, first);
    repeat (len - 1) send_item(psma_pkg::MODE_BYTE, 8'($urandom_range(0, 255)));
  endtask

  // Hold off until every pop has returned and the block has settled
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [2:0] v);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    size_now = v;
    cfg_writes++;
  endtask

  // Mix of packets, noise bytes and pops
  task automatic mixed_traffic(input int n);
    int start;
    int r;
    start = items_sent;
    while (items_sent - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 55) send_random_packet(1'b1);
      else if (r < 70) send_item(psma_pkg::MODE_BYTE, 8'($urandom_range(0, 255)));
      else send_pop();
    end
  endtask

  // Overfill the event ring, then drain it past empty
  task automatic flood_queue();
    repeat (QUEUE_DEPTH + 4) send_random_packet(1'b0);
    repeat (QUEUE_DEPTH + 2) send_pop();
    floods_done++;
  endtask

  initial begin
    int base;
    int phase;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // pop on an empty queue
    send_pop();
    // drop start bytes lacking the sync bit
    send_item(psma_pkg::MODE_BYTE, 8'h00);
    send_item(psma_pkg::MODE_BYTE, 8'hF7);
    // 3-byte packets at field extremes
    send_item(psma_pkg::MODE_BYTE, 8'hFF);
    send_item(psma_pkg::MODE_BYTE, 8'h80);
    send_item(psma_pkg::MODE_BYTE, 8'h7F);
    send_item(psma_pkg::MODE_BYTE, 8'h08);
    send_item(psma_pkg::MODE_BYTE, 8'h00);
    send_item(psma_pkg::MODE_BYTE, 8'hFF);
    repeat (3) send_pop();

    // wheel packet
    write_size(psma_pkg::PKT_BYTES_WHEEL);
    send_item(psma_pkg::MODE_BYTE, 8'h0F);
    send_item(psma_pkg::MODE_BYTE, 8'h01);
    send_item(psma_pkg::MODE_BYTE, 8'hFF);
    send_item(psma_pkg::MODE_BYTE, 8'h80);
    send_pop();

    // shrink to 3 with three bytes held: fourth byte completes, wheel zero
    send_item(psma_pkg::MODE_BYTE, 8'h09);
    send_item(psma_pkg::MODE_BYTE, 8'h10);
    send_item(psma_pkg::MODE_BYTE, 8'h20);
    write_size(psma_pkg::PKT_BYTES_RESET);
    send_item(psma_pkg::MODE_BYTE, 8'h55);
    send_pop();

    // grow to 4 with two bytes held
    send_item(psma_pkg::MODE_BYTE, 8'h0A);
    send_item(psma_pkg::MODE_BYTE, 8'h11);
    write_size(psma_pkg::PKT_BYTES_WHEEL);
    send_item(psma_pkg::MODE_BYTE, 8'h22);
    send_item(psma_pkg::MODE_BYTE, 8'h7F);
    send_pop();

    // random phases: every size value first, then random sizes
    base  = items_sent;
    phase = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      calm = 1'b0;
      if (phase < 8) write_size(phase[2:0]);
      else if (phase % 3 == 0) write_size(psma_pkg::PKT_BYTES_WHEEL);
      else write_size(3'($urandom_range(0, 7)));
      calm = ($urandom_range(0, 3) == 0);
      if (phase % 5 == 2) flood_queue();
      else mixed_traffic(100);
      phase++;
    end
    calm = 1'b0;

    wait_quiet();
    $display("Covered %0d items (%0d pops), %0d queue overflows, %0d packet size writes",
             items_sent, pops_sent, floods_done, cfg_writes);
    $display("including every size value, resync drops and mid-packet size changes.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
